@@ src/sfcd_pkg.sv @@
`default_nettype none
package sfcd_pkg;

  localparam int OpWidth = 2;

  localparam logic [OpWidth-1:0] OP_BYTE      = 2'd0;
  localparam logic [OpWidth-1:0] OP_FULL_READ = 2'd1;
  localparam logic [OpWidth-1:0] OP_RECAL     = 2'd2;

  // Byte positions inside the nine-byte frame.
  localparam logic [3:0] POS_TEMP_HI  = 4'd3;
  localparam logic [3:0] POS_TEMP_LO  = 4'd4;
  localparam logic [3:0] POS_TEMP_CRC = 4'd5;
  localparam logic [3:0] POS_HUM_HI   = 4'd6;
  localparam logic [3:0] POS_HUM_LO   = 4'd7;
  localparam logic [3:0] POS_HUM_CRC  = 4'd8;
  localparam logic [3:0] FRAME_LEN    = 4'd9;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [16:0] RAW_FULL    = 17'd65535;
  localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;

  typedef struct packed {
    logic        fire;
    logic        crc_error;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic [15:0] held_co2;
  } sfcd_status_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/sfcd_frame.sv @@
`default_nettype none
module sfcd_frame (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     valid,
  input  wire logic                     go,
  input  wire logic [1:0]               op,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     frame_start,
  input  wire logic [15:0]              co2_value,
  output sfcd_pkg::sfcd_status_t        status
);
  import sfcd_pkg::*;

  logic [3:0]  byte_count, byte_count_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] temp_raw, temp_raw_next;
  logic [15:0] hum_raw, hum_raw_next;
  logic        crc_bad, crc_bad_next;
  logic [15:0] held_co2, held_co2_next;

  logic [3:0]  pos;
  logic [7:0]  crc_eff;
  logic        bad_eff;
  logic [7:0]  crc_new;
  logic        is_byte;

  // A frame start restarts the frame before this byte is looked at.
  assign pos     = frame_start ? 4'd0 : byte_count;
  assign crc_eff = frame_start ? CRC_INIT : running_crc;
  assign bad_eff = frame_start ? 1'b0 : crc_bad;
  assign is_byte = (op == OP_BYTE);
  assign crc_new = crc_feed((pos == POS_TEMP_HI || pos == POS_HUM_HI) ? CRC_INIT : crc_eff,
                            data_byte);

  always_comb begin
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    temp_raw_next    = temp_raw;
    hum_raw_next     = hum_raw;
    crc_bad_next     = crc_bad;
    held_co2_next    = held_co2;
    if (go) begin
      case (op)
        OP_FULL_READ: held_co2_next = co2_value;
        OP_RECAL:     held_co2_next = 16'd0;
        OP_BYTE: begin
          byte_count_next  = pos;
          running_crc_next = crc_eff;
          crc_bad_next     = bad_eff;
          if (pos < FRAME_LEN) begin
            case (pos)
              POS_TEMP_HI: begin
                running_crc_next = crc_new;
                temp_raw_next    = {data_byte, 8'd0};
              end
              POS_TEMP_LO: begin
                running_crc_next = crc_new;
                temp_raw_next    = {temp_raw[15:8], data_byte};
              end
              POS_HUM_HI: begin
                running_crc_next = crc_new;
                hum_raw_next     = {data_byte, 8'd0};
              end
              POS_HUM_LO: begin
                running_crc_next = crc_new;
                hum_raw_next     = {hum_raw[15:8], data_byte};
              end
              POS_TEMP_CRC, POS_HUM_CRC: begin
                if (crc_eff != data_byte) begin
                  crc_bad_next = 1'b1;
                end
              end
              default: ;
            endcase
            byte_count_next = (pos == POS_HUM_CRC) ? FRAME_LEN : pos + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= FRAME_LEN;
      running_crc <= CRC_INIT;
      temp_raw    <= 16'd0;
      hum_raw     <= 16'd0;
      crc_bad     <= 1'b0;
      held_co2    <= 16'd0;
    end else begin
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
      temp_raw    <= temp_raw_next;
      hum_raw     <= hum_raw_next;
      crc_bad     <= crc_bad_next;
      held_co2    <= held_co2_next;
    end
  end

  // The last byte is the humidity CRC; both raw words are already stored.
  assign status.fire      = valid && is_byte && (pos == POS_HUM_CRC);
  assign status.crc_error = bad_eff || (crc_eff != data_byte);
  assign status.temp_raw  = temp_raw;
  assign status.hum_raw   = hum_raw;
  assign status.held_co2  = held_co2;

endmodule
`default_nettype wire

@@ src/sfcd_scale.sv @@
`default_nettype none
module sfcd_scale (
  input  wire logic [15:0]        temp_raw,
  input  wire logic [15:0]        hum_raw,
  output logic signed [14:0]      temp_centi,
  output logic [13:0]             hum_centi
);
  import sfcd_pkg::*;

  logic [30:0] t_prod;
  logic [29:0] h_prod;
  logic [16:0] t_sum;
  logic [16:0] h_sum;
  logic [14:0] t_quo;
  logic [13:0] h_quo;
  logic signed [15:0] t_wide;

  // With p = a*2^16 + b, p = a*65535 + (a + b), and a + b stays below
  // twice 65535, so one compare finishes the division.
  assign t_prod = {15'd0, temp_raw} * {16'd0, TEMP_SPAN};
  assign h_prod = {14'd0, hum_raw} * {16'd0, HUM_SPAN};
  assign t_sum  = {2'd0, t_prod[30:16]} + {1'b0, t_prod[15:0]};
  assign h_sum  = {3'd0, h_prod[29:16]} + {1'b0, h_prod[15:0]};
  assign t_quo  = t_prod[30:16] + ((t_sum >= RAW_FULL) ? 15'd1 : 15'd0);
  assign h_quo  = h_prod[29:16] + ((h_sum >= RAW_FULL) ? 14'd1 : 14'd0);
  assign t_wide = $signed({1'b0, t_quo}) + TEMP_OFFSET;

  assign temp_centi = t_wide[14:0];
  assign hum_centi  = h_quo;

endmodule
`default_nettype wire

@@ src/sensor_frame_crc_decode_top.sv @@
// Channel  Handshake                 Payload
// in       in_valid / in_ready       op, data_byte, frame_start, co2_value
// out      out_valid / out_ready     temp_centi, hum_centi, co2_ppm, crc_error
//
// An item waits in the input register; the ninth frame byte loads the result
// register from there once it is free, and out_valid rises with that load.
// One item is taken every cycle; the input register holds only while a finished
// result waits in the output register and the held item would make another.
// Synchronous reset closes any open frame and clears the held CO2 value.
`default_nettype none
module sensor_frame_crc_decode_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         op,
  input  wire logic [7:0]         data_byte,
  input  wire logic               frame_start,
  input  wire logic [15:0]        co2_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [14:0]      temp_centi,
  output logic [13:0]             hum_centi,
  output logic [15:0]             co2_ppm,
  output logic                    crc_error
);
  import sfcd_pkg::*;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [7:0]  s1_byte;
  logic        s1_start;
  logic [15:0] s1_co2;

  sfcd_status_t     status;
  logic             s1_go;
  logic             out_load;
  logic signed [14:0] temp_scaled;
  logic [13:0]      hum_scaled;

  assign out_load = status.fire && (!out_valid || out_ready);
  assign s1_go    = s1_valid && (!status.fire || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op    <= op;
      s1_byte  <= data_byte;
      s1_start <= frame_start;
      s1_co2   <= co2_value;
    end
  end

  sfcd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .valid       (s1_valid),
    .go          (s1_go),
    .op          (s1_op),
    .data_byte   (s1_byte),
    .frame_start (s1_start),
    .co2_value   (s1_co2),
    .status      (status)
  );

  sfcd_scale u_scale (
    .temp_raw   (status.temp_raw),
    .hum_raw    (status.hum_raw),
    .temp_centi (temp_scaled),
    .hum_centi  (hum_scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A CRC failure reports the flag with all values zero.
  always_ff @(posedge clk) begin
    if (out_load) begin
      crc_error  <= status.crc_error;
      temp_centi <= status.crc_error ? 15'sd0 : temp_scaled;
      hum_centi  <= status.crc_error ? 14'd0 : hum_scaled;
      co2_ppm    <= status.crc_error ? 16'd0 : status.held_co2;
    end
  end

endmodule
`default_nettype wire
